// ===== hdl/sha256_pkg.sv =====
`default_nettype none
package sha256_pkg;

  localparam int BlockBytes = 64;
  localparam int Rounds     = 64;
  localparam int CountWidth = 61;
  localparam logic [7:0] PadByte = 8'h80;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam logic [31:0] InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_part;
    logic [1:0]  part_index;
    logic        last_part;
  } out_item_t;

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

// ===== hdl/sha256_if.sv =====
`default_nettype none
interface sha256_in_if;
  logic                    valid;
  logic                    ready;
  sha256_pkg::in_item_t    payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface sha256_out_if;
  logic                    valid;
  logic                    ready;
  sha256_pkg::out_item_t   payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== hdl/sha256_byte_stream_hasher.sv =====
`default_nettype none
// channel | dir | payload
// in      | in  | data_byte, byte_present, end_of_message
// out     | out | digest_part, part_index, last_part
// A byte without end mark is stored; a byte that fills a block starts
// a load, 64 rounds and a fold: schedule words come from the block
// memory (one registered read a cycle) and a rolling 16-word window.
// A final item pads into the memory one byte per cycle up to the end of the
// block, once or twice, each padded block passing through load, rounds and
// fold, then offers four parts; a stall on out holds the part. Synchronous
// reset restores the initial hash values.
module sha256_byte_stream_hasher (
  input  wire logic  clk,
  input  wire logic  rst,
  sha256_in_if.sink    in_ch,
  sha256_out_if.source out_ch
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PAD   = 6'b000010,
    S_LOAD  = 6'b000100,
    S_ROUND = 6'b001000,
    S_FOLD  = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state;
  logic [31:0] word_mem   [16];
  logic [31:0] h [8];
  logic [31:0] v [8];
  logic [31:0] w [16];
  logic [5:0]  fill;
  logic [60:0] count;
  logic [63:0] bits;
  logic        padding;
  logic        tail_done;
  logic        len_ok;
  logic        len_done;
  logic [5:0]  round;
  logic [1:0]  part;
  logic [31:0] rd_word;
  logic [3:0]  rd_addr;

  logic        wr_en;
  logic [5:0]  wr_addr;
  logic [7:0]  wr_data;
  logic [7:0]  pad_byte;
  logic [63:0] len_bytes;
  logic [31:0] w_cur, w_new, s0, s1, t1, t2;

  // block memory, one byte lane written per input or pad byte, one word read a cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      unique case (wr_addr[1:0])
        2'd0: word_mem[wr_addr[5:2]][31:24] <= wr_data;
        2'd1: word_mem[wr_addr[5:2]][23:16] <= wr_data;
        2'd2: word_mem[wr_addr[5:2]][15:8]  <= wr_data;
        default: word_mem[wr_addr[5:2]][7:0] <= wr_data;
      endcase
    end
    rd_word <= word_mem[rd_addr];
  end

  // fetch the word for the next round through the registered read during the current round
  assign rd_addr = (state == S_ROUND) ? round[3:0] + 4'd1 : 4'd0;

  always_comb begin
    len_bytes = bits << {fill[2:0], 3'b000};
    if (!tail_done) pad_byte = sha256_pkg::PadByte;
    else if (len_ok && fill >= 6'd56) pad_byte = len_bytes[63:56];
    else pad_byte = 8'd0;
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = fill;
    wr_data = in_ch.payload.data_byte;
    if (state == S_IDLE && in_ch.valid && in_ch.payload.byte_present) wr_en = 1'b1;
    if (state == S_PAD) begin
      wr_en   = 1'b1;
      wr_data = pad_byte;
    end
  end

  always_comb begin
    s0 = sha256_pkg::ror(w[1], 7) ^ sha256_pkg::ror(w[1], 18) ^ (w[1] >> 3);
    s1 = sha256_pkg::ror(w[14], 17) ^ sha256_pkg::ror(w[14], 19) ^ (w[14] >> 10);
    w_new = w[0] + s0 + w[9] + s1;
    w_cur = (round < 6'd16) ? rd_word : w_new;
    t1 = v[7] + (sha256_pkg::ror(v[4], 6) ^ sha256_pkg::ror(v[4], 11)
         ^ sha256_pkg::ror(v[4], 25)) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
         + sha256_pkg::RoundK[round] + w_cur;
    t2 = (sha256_pkg::ror(v[0], 2) ^ sha256_pkg::ror(v[0], 13) ^ sha256_pkg::ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  end

  assign in_ch.ready  = (state == S_IDLE);
  assign out_ch.valid = (state == S_OUT);
  assign out_ch.payload.digest_part = {h[{part, 1'b0}], h[{part, 1'b1}]};
  assign out_ch.payload.part_index  = part;
  assign out_ch.payload.last_part   = (part == 2'd3);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill <= '0;
      count <= '0;
      padding <= 1'b0;
      tail_done <= 1'b0;
      len_ok <= 1'b0;
      len_done <= 1'b0;
      round <= '0;
      part <= '0;
      for (int i = 0; i < 8; i++) h[i] <= sha256_pkg::InitH[i];
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            if (in_ch.payload.byte_present) begin
              fill  <= fill + 6'd1;
              count <= count + 61'd1;
            end
            bits <= {(count + 61'(in_ch.payload.byte_present)), 3'b000};
            padding   <= in_ch.payload.end_of_message;
            tail_done <= 1'b0;
            len_ok    <= 1'b0;
            len_done  <= 1'b0;
            if (in_ch.payload.byte_present && fill == 6'd63) state <= S_LOAD;
            else if (in_ch.payload.end_of_message) state <= S_PAD;
          end
        end
        S_PAD: begin
          // 0x80 first; the length fits in this block only if 0x80 lands before 56
          fill <= fill + 6'd1;
          if (!tail_done) begin
            tail_done <= 1'b1;
            len_ok    <= (fill < 6'd56);
          end
          if (fill == 6'd63) begin
            state <= S_LOAD;
            if (tail_done && len_ok) len_done <= 1'b1;
          end
        end
        S_LOAD: begin
          for (int i = 0; i < 8; i++) v[i] <= h[i];
          round <= '0;
          state <= S_ROUND;
        end
        S_ROUND: begin
          for (int i = 0; i < 15; i++) w[i] <= w[i+1];
          w[15] <= w_cur;
          v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
          v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
          round <= round + 6'd1;
          if (round == 6'd63) state <= S_FOLD;
        end
        S_FOLD: begin
          for (int i = 0; i < 8; i++) h[i] <= h[i] + v[i];
          if (!padding) state <= S_IDLE;
          else if (len_done) state <= S_OUT;
          else begin
            // next block carries the length at its end
            len_ok <= 1'b1;
            state  <= S_PAD;
          end
        end
        S_OUT: begin
          if (out_ch.ready) begin
            part <= part + 2'd1;
            if (part == 2'd3) begin
              state <= S_IDLE;
              count <= '0;
              fill <= '0;
              padding <= 1'b0;
              tail_done <= 1'b0;
              len_ok <= 1'b0;
              len_done <= 1'b0;
              for (int i = 0; i < 8; i++) h[i] <= sha256_pkg::InitH[i];
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
